[design/vmcb_pkg.sv]
// Shared types and constants of the view matrix basis pipeline.
`default_nettype none

package vmcb_pkg;

    localparam int POS_W    = 32;
    localparam int DIR_W    = 16;
    localparam int UNIT_W   = 16;
    localparam int CROSS_W  = 32;
    localparam int MAG_W    = CROSS_W - 1;
    localparam int SHIFT_W  = 5;
    localparam int SQR_W    = 2 * MAG_W;
    localparam int SUM_W    = SQR_W + 2;
    localparam int LEN_W    = SUM_W / 2;

    localparam int SQRT_STEPS  = 2;
    localparam int SQRT_STAGES = LEN_W / SQRT_STEPS;
    localparam int SQRT_REM_W  = LEN_W + 4;

    localparam int QUO_W      = 15;
    localparam int DIV_STEPS  = 3;
    localparam int DIV_STAGES = (QUO_W + DIV_STEPS - 1) / DIV_STEPS;
    localparam int DEN_W      = LEN_W + 1;
    localparam int NUM_W      = MAG_W + QUO_W + 1;

    localparam int NORM_LAT = 7 + SQRT_STAGES + DIV_STAGES;
    localparam int UNIT_ONE = 16384;

    localparam int PROD_W      = POS_W + UNIT_W;
    localparam int DOT_W       = PROD_W + 2;
    localparam int ROUND_SHIFT = 14;
    localparam int ROUND_BIAS  = 8192;
    localparam int QT_W        = DOT_W - ROUND_SHIFT;

    typedef logic signed [CROSS_W-1:0] t_cross;
    typedef logic signed [UNIT_W-1:0]  t_unit;
    typedef logic signed [DIR_W-1:0]   t_dir;
    typedef logic signed [POS_W-1:0]   t_pos;

    typedef struct packed {
        logic signed [POS_W-1:0] pos_x;
        logic signed [POS_W-1:0] pos_y;
        logic signed [POS_W-1:0] pos_z;
        logic signed [DIR_W-1:0] up_in_x;
        logic signed [DIR_W-1:0] up_in_y;
        logic signed [DIR_W-1:0] up_in_z;
        logic signed [DIR_W-1:0] look_in_x;
        logic signed [DIR_W-1:0] look_in_y;
        logic signed [DIR_W-1:0] look_in_z;
    } t_in_item;

    typedef struct packed {
        logic signed [UNIT_W-1:0] right_x;
        logic signed [UNIT_W-1:0] right_y;
        logic signed [UNIT_W-1:0] right_z;
        logic signed [UNIT_W-1:0] up_out_x;
        logic signed [UNIT_W-1:0] up_out_y;
        logic signed [UNIT_W-1:0] up_out_z;
        logic signed [UNIT_W-1:0] look_out_x;
        logic signed [UNIT_W-1:0] look_out_y;
        logic signed [UNIT_W-1:0] look_out_z;
        logic signed [POS_W-1:0]  trans_x;
        logic signed [POS_W-1:0]  trans_y;
        logic signed [POS_W-1:0]  trans_z;
    } t_out_item;

endpackage

`default_nettype wire

[design/vmcb_normalize.sv]
// Pipelined three-component vector normalizer: scale, square sum, root, divide.
`default_nettype none

module vmcb_normalize (
    input  wire logic             i_clk,
    input  wire logic             i_ce,
    input  wire vmcb_pkg::t_cross i_vec [3],
    output vmcb_pkg::t_unit       o_unit [3]
);

    localparam int MAG_W   = vmcb_pkg::MAG_W;
    localparam int SHIFT_W = vmcb_pkg::SHIFT_W;
    localparam int SQR_W   = vmcb_pkg::SQR_W;
    localparam int SUM_W   = vmcb_pkg::SUM_W;
    localparam int LEN_W   = vmcb_pkg::LEN_W;
    localparam int SQS     = vmcb_pkg::SQRT_STAGES;
    localparam int SQK     = vmcb_pkg::SQRT_STEPS;
    localparam int SRW     = vmcb_pkg::SQRT_REM_W;
    localparam int QUO_W   = vmcb_pkg::QUO_W;
    localparam int DVS     = vmcb_pkg::DIV_STAGES;
    localparam int DVK     = vmcb_pkg::DIV_STEPS;
    localparam int DEN_W   = vmcb_pkg::DEN_W;
    localparam int NUM_W   = vmcb_pkg::NUM_W;
    localparam int UNIT_W  = vmcb_pkg::UNIT_W;

    // Magnitudes and signs.
    logic [MAG_W-1:0]   r_m1_mag [3];
    logic               r_m1_neg [3];
    // Shift that brings the largest magnitude to the top.
    logic [MAG_W-1:0]   r_m2_mag [3];
    logic               r_m2_neg [3];
    logic [SHIFT_W-1:0] r_m2_sh;
    logic               r_m2_zero;
    // Scaled magnitudes.
    logic [MAG_W-1:0]   r_m3_smag [3];
    logic               r_m3_neg [3];
    logic               r_m3_zero;
    // Squares.
    logic [SQR_W-1:0]   r_m4_sq [3];
    logic [MAG_W-1:0]   r_m4_smag [3];
    logic               r_m4_neg [3];
    logic               r_m4_zero;
    // Square root pipeline.
    logic [SUM_W-1:0]   r_sq_x    [SQS];
    logic [SRW-1:0]     r_sq_rem  [SQS];
    logic [LEN_W-1:0]   r_sq_root [SQS+1];
    logic [MAG_W-1:0]   r_sq_smag [SQS+1][3];
    logic               r_sq_neg  [SQS+1][3];
    logic               r_sq_zero [SQS+1];
    // Divider pipeline.
    logic [DEN_W-1:0]   r_dv_rem  [DVS][3];
    logic [QUO_W-1:0]   r_dv_low  [DVS][3];
    logic [DEN_W-1:0]   r_dv_d    [DVS];
    logic [QUO_W-1:0]   r_dv_q    [DVS+1][3];
    logic               r_dv_neg  [DVS+1][3];
    logic               r_dv_zero [DVS+1];
    vmcb_pkg::t_unit    r_out [3];

    logic [MAG_W-1:0]   n_m1_mag [3];
    logic [MAG_W-1:0]   n_or;
    logic [SHIFT_W-1:0] n_msb;
    logic [NUM_W-1:0]   n_num [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_m1_mag[i] = i_vec[i][vmcb_pkg::CROSS_W-1]
                        ? MAG_W'(-i_vec[i]) : MAG_W'(i_vec[i]);
        end
    end

    always_comb begin
        n_or  = r_m1_mag[0] | r_m1_mag[1] | r_m1_mag[2];
        n_msb = '0;
        for (int b = 0; b < MAG_W; b++) begin
            if (n_or[b]) begin
                n_msb = SHIFT_W'(b);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            for (int i = 0; i < 3; i++) begin
                r_m1_mag[i]  <= n_m1_mag[i];
                r_m1_neg[i]  <= i_vec[i][vmcb_pkg::CROSS_W-1];
                r_m2_mag[i]  <= r_m1_mag[i];
                r_m2_neg[i]  <= r_m1_neg[i];
                r_m3_smag[i] <= r_m2_mag[i] << r_m2_sh;
                r_m3_neg[i]  <= r_m2_neg[i];
                r_m4_sq[i]   <= SQR_W'(r_m3_smag[i]) * SQR_W'(r_m3_smag[i]);
                r_m4_smag[i] <= r_m3_smag[i];
                r_m4_neg[i]  <= r_m3_neg[i];
                r_sq_smag[0][i] <= r_m4_smag[i];
                r_sq_neg[0][i]  <= r_m4_neg[i];
            end
            r_m2_sh    <= SHIFT_W'(MAG_W - 1) - n_msb;
            r_m2_zero  <= (n_or == '0);
            r_m3_zero  <= r_m2_zero;
            r_m4_zero  <= r_m3_zero;
            r_sq_x[0]  <= SUM_W'(r_m4_sq[0]) + SUM_W'(r_m4_sq[1]) + SUM_W'(r_m4_sq[2]);
            r_sq_rem[0]  <= '0;
            r_sq_root[0] <= '0;
            r_sq_zero[0] <= r_m4_zero;
        end
    end

    // Integer square root, two result bits per stage.
    for (genvar gs = 0; gs < SQS; gs++) begin : g_sqrt
        logic [SRW-1:0]   n_rem;
        logic [LEN_W-1:0] n_root;

        always_comb begin
            logic [SRW-1:0]   rem;
            logic [LEN_W-1:0] root;
            logic [SRW-1:0]   trial;
            rem  = r_sq_rem[gs];
            root = r_sq_root[gs];
            for (int k = 0; k < SQK; k++) begin
                rem   = {rem[SRW-3:0], r_sq_x[gs][2 * (LEN_W - 1 - (gs * SQK + k)) +: 2]};
                trial = SRW'({root, 2'b01});
                if (rem >= trial) begin
                    rem  = rem - trial;
                    root = {root[LEN_W-2:0], 1'b1};
                end else begin
                    root = {root[LEN_W-2:0], 1'b0};
                end
            end
            n_rem  = rem;
            n_root = root;
        end

        always_ff @(posedge i_clk) begin
            if (i_ce) begin
                r_sq_root[gs+1] <= n_root;
                r_sq_zero[gs+1] <= r_sq_zero[gs];
                for (int i = 0; i < 3; i++) begin
                    r_sq_smag[gs+1][i] <= r_sq_smag[gs][i];
                    r_sq_neg[gs+1][i]  <= r_sq_neg[gs][i];
                end
            end
        end

        if (gs < SQS - 1) begin : g_next
            always_ff @(posedge i_clk) begin
                if (i_ce) begin
                    r_sq_rem[gs+1] <= n_rem;
                    r_sq_x[gs+1]   <= r_sq_x[gs];
                end
            end
        end
    end

    // Numerator |c| * 2^15 + len; the quotient by 2 * len is the rounded unit value.
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_num[i] = NUM_W'({r_sq_smag[SQS][i], QUO_W'(0)}) + NUM_W'(r_sq_root[SQS]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            for (int i = 0; i < 3; i++) begin
                r_dv_rem[0][i] <= DEN_W'(n_num[i][NUM_W-1:QUO_W]);
                r_dv_low[0][i] <= n_num[i][QUO_W-1:0];
                r_dv_q[0][i]   <= '0;
                r_dv_neg[0][i] <= r_sq_neg[SQS][i];
            end
            r_dv_d[0]    <= {r_sq_root[SQS], 1'b0};
            r_dv_zero[0] <= r_sq_zero[SQS];
        end
    end

    // Restoring division, three quotient bits per stage.
    for (genvar gd = 0; gd < DVS; gd++) begin : g_div
        logic [DEN_W-1:0] n_rem [3];
        logic [QUO_W-1:0] n_q   [3];

        always_comb begin
            logic [DEN_W:0]   rem;
            logic [QUO_W-1:0] q;
            for (int i = 0; i < 3; i++) begin
                rem = {1'b0, r_dv_rem[gd][i]};
                q   = r_dv_q[gd][i];
                for (int k = 0; k < DVK; k++) begin
                    if (gd * DVK + k < QUO_W) begin
                        rem = {rem[DEN_W-1:0], r_dv_low[gd][i][QUO_W - 1 - (gd * DVK + k)]};
                        if (rem >= {1'b0, r_dv_d[gd]}) begin
                            rem = rem - {1'b0, r_dv_d[gd]};
                            q   = {q[QUO_W-2:0], 1'b1};
                        end else begin
                            q   = {q[QUO_W-2:0], 1'b0};
                        end
                    end
                end
                n_rem[i] = rem[DEN_W-1:0];
                n_q[i]   = q;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_ce) begin
                for (int i = 0; i < 3; i++) begin
                    r_dv_q[gd+1][i]   <= n_q[i];
                    r_dv_neg[gd+1][i] <= r_dv_neg[gd][i];
                end
                r_dv_zero[gd+1] <= r_dv_zero[gd];
            end
        end

        if (gd < DVS - 1) begin : g_next
            always_ff @(posedge i_clk) begin
                if (i_ce) begin
                    for (int i = 0; i < 3; i++) begin
                        r_dv_rem[gd+1][i] <= n_rem[i];
                        r_dv_low[gd+1][i] <= r_dv_low[gd][i];
                    end
                    r_dv_d[gd+1] <= r_dv_d[gd];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            for (int i = 0; i < 3; i++) begin
                if (r_dv_zero[DVS]) begin
                    r_out[i] <= '0;
                end else if (r_dv_q[DVS][i] > QUO_W'(vmcb_pkg::UNIT_ONE)) begin
                    r_out[i] <= r_dv_neg[DVS][i] ? -UNIT_W'(vmcb_pkg::UNIT_ONE)
                                                  :  UNIT_W'(vmcb_pkg::UNIT_ONE);
                end else begin
                    r_out[i] <= r_dv_neg[DVS][i] ? -UNIT_W'(r_dv_q[DVS][i])
                                                  :  UNIT_W'(r_dv_q[DVS][i]);
                end
            end
        end
    end

    assign o_unit = r_out;

endmodule

`default_nettype wire

[design/view_matrix_from_camera_basis.sv]
// Left-handed look-at view matrix basis: top level pipeline.
//
// The input channel takes one camera item: a Q16.16 position and Q2.13 up and
// look directions. The output channel gives the Q1.14 right, up and look axes
// and the three Q16.16 translation terms, each the rounded and saturated
// negative dot product of the position with one axis.
// Both channels use valid and stall. An item is accepted when valid is high
// and stall is low.
// Throughput is one item per cycle while the receiver does not stall. The
// second cross product needs the normalized right axis, so two normalizer
// pipelines (scale, square sum, 2-bit-per-stage root, 3-bit-per-stage
// divide) stand in series.
// When the receiver stalls while a result is waiting, the whole pipeline
// holds and the input stall rises; nothing is lost or repeated.
// Reset clears only the valid bits, so the pipeline comes up empty.
`default_nettype none

module view_matrix_from_camera_basis (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    output logic                      o_in_stall,
    input  wire vmcb_pkg::t_in_item   i_in_data,
    output logic                      o_out_valid,
    input  wire logic                 i_out_stall,
    output vmcb_pkg::t_out_item       o_out_data
);

    localparam int NL      = vmcb_pkg::NORM_LAT;
    localparam int LAT     = 2 * NL + 8;
    localparam int LKD     = NL + 1;
    localparam int PD      = 2 * NL + 3;
    localparam int RD      = NL + 2;
    localparam int CROSS_W = vmcb_pkg::CROSS_W;
    localparam int PROD_W  = vmcb_pkg::PROD_W;
    localparam int DOT_W   = vmcb_pkg::DOT_W;
    localparam int QT_W    = vmcb_pkg::QT_W;
    localparam int POS_W   = vmcb_pkg::POS_W;

    logic w_ce;

    logic [LAT-1:0]   r_vld;

    vmcb_pkg::t_pos   r_a_pos [3];
    vmcb_pkg::t_dir   r_a_lk  [3];
    vmcb_pkg::t_cross r_a_pl  [3];
    vmcb_pkg::t_cross r_a_pr  [3];
    vmcb_pkg::t_cross r_b_c   [3];

    vmcb_pkg::t_dir   r_lk_d  [LKD][3];
    vmcb_pkg::t_pos   r_pos_d [PD][3];
    vmcb_pkg::t_unit  r_r_d   [RD][3];
    vmcb_pkg::t_unit  r_l_d   [RD][3];

    vmcb_pkg::t_cross r_c_pl  [3];
    vmcb_pkg::t_cross r_c_pr  [3];
    vmcb_pkg::t_cross r_d_c   [3];

    logic signed [PROD_W-1:0] r_e_prod [3][3];
    logic signed [DOT_W-1:0]  r_f_dot  [3];
    logic [DOT_W-1:0]         r_g_mag  [3];
    logic                     r_g_neg  [3];
    vmcb_pkg::t_unit          r_ax_d   [3][3][3];
    vmcb_pkg::t_out_item      r_out;

    vmcb_pkg::t_pos   n_pos [3];
    vmcb_pkg::t_dir   n_up  [3];
    vmcb_pkg::t_dir   n_lk  [3];
    vmcb_pkg::t_cross w_lk_vec [3];
    vmcb_pkg::t_unit  w_right [3];
    vmcb_pkg::t_unit  w_look  [3];
    vmcb_pkg::t_unit  w_up    [3];
    vmcb_pkg::t_unit  w_axis  [3][3];
    logic [QT_W-1:0]         n_q [3];
    logic signed [POS_W-1:0] n_t [3];

    // The pipeline moves unless a finished result is held by the receiver.
    assign w_ce        = !(r_vld[LAT-1] && i_out_stall);
    assign o_in_stall  = !w_ce;
    assign o_out_valid = r_vld[LAT-1];
    assign o_out_data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_ce) begin
            r_vld <= {r_vld[LAT-2:0], i_in_valid};
        end
    end

    always_comb begin
        n_pos[0] = i_in_data.pos_x;
        n_pos[1] = i_in_data.pos_y;
        n_pos[2] = i_in_data.pos_z;
        n_up[0]  = i_in_data.up_in_x;
        n_up[1]  = i_in_data.up_in_y;
        n_up[2]  = i_in_data.up_in_z;
        n_lk[0]  = i_in_data.look_in_x;
        n_lk[1]  = i_in_data.look_in_y;
        n_lk[2]  = i_in_data.look_in_z;
        for (int i = 0; i < 3; i++) begin
            w_lk_vec[i] = CROSS_W'(r_lk_d[0][i]);
            w_axis[0][i] = r_r_d[RD-1][i];
            w_axis[1][i] = w_up[i];
            w_axis[2][i] = r_l_d[RD-1][i];
        end
    end

    // First cross product, up x look, and the delay lines that follow it.
    always_ff @(posedge i_clk) begin
        if (w_ce) begin
            for (int i = 0; i < 3; i++) begin
                r_a_pos[i] <= n_pos[i];
                r_a_lk[i]  <= n_lk[i];
                r_a_pl[i]  <= CROSS_W'(n_up[(i + 1) % 3]) * CROSS_W'(n_lk[(i + 2) % 3]);
                r_a_pr[i]  <= CROSS_W'(n_up[(i + 2) % 3]) * CROSS_W'(n_lk[(i + 1) % 3]);
                r_b_c[i]   <= r_a_pl[i] - r_a_pr[i];
                r_lk_d[0][i]  <= r_a_lk[i];
                r_pos_d[0][i] <= r_a_pos[i];
                for (int k = 1; k < LKD; k++) begin
                    r_lk_d[k][i] <= r_lk_d[k-1][i];
                end
                for (int k = 1; k < PD; k++) begin
                    r_pos_d[k][i] <= r_pos_d[k-1][i];
                end
            end
        end
    end

    vmcb_normalize u_norm_right (
        .i_clk  (i_clk),
        .i_ce   (w_ce),
        .i_vec  (r_b_c),
        .o_unit (w_right)
    );

    vmcb_normalize u_norm_look (
        .i_clk  (i_clk),
        .i_ce   (w_ce),
        .i_vec  (w_lk_vec),
        .o_unit (w_look)
    );

    // Second cross product, look x right, with the raw look direction.
    always_ff @(posedge i_clk) begin
        if (w_ce) begin
            for (int i = 0; i < 3; i++) begin
                r_c_pl[i] <= CROSS_W'(r_lk_d[LKD-1][(i + 1) % 3]) * CROSS_W'(w_right[(i + 2) % 3]);
                r_c_pr[i] <= CROSS_W'(r_lk_d[LKD-1][(i + 2) % 3]) * CROSS_W'(w_right[(i + 1) % 3]);
                r_d_c[i]  <= r_c_pl[i] - r_c_pr[i];
                r_r_d[0][i] <= w_right[i];
                r_l_d[0][i] <= w_look[i];
                for (int k = 1; k < RD; k++) begin
                    r_r_d[k][i] <= r_r_d[k-1][i];
                    r_l_d[k][i] <= r_l_d[k-1][i];
                end
            end
        end
    end

    vmcb_normalize u_norm_up (
        .i_clk  (i_clk),
        .i_ce   (w_ce),
        .i_vec  (r_d_c),
        .o_unit (w_up)
    );

    // Rounding half away from zero, then negation with saturation.
    always_comb begin
        for (int a = 0; a < 3; a++) begin
            n_q[a] = QT_W'(r_g_mag[a] >> vmcb_pkg::ROUND_SHIFT);
            if (r_g_neg[a]) begin
                n_t[a] = (n_q[a] > QT_W'(32'h7FFF_FFFF)) ? POS_W'(32'h7FFF_FFFF)
                                                          : POS_W'(n_q[a]);
            end else begin
                n_t[a] = (n_q[a] > QT_W'(33'h1_0000_0000 >> 1)) ? POS_W'(32'h8000_0000)
                                                                 : POS_W'(-n_q[a]);
            end
        end
    end

    // Translation: products, sums, rounding and the output register.
    always_ff @(posedge i_clk) begin
        if (w_ce) begin
            for (int a = 0; a < 3; a++) begin
                for (int j = 0; j < 3; j++) begin
                    r_e_prod[a][j] <= PROD_W'(r_pos_d[PD-1][j]) * PROD_W'(w_axis[a][j]);
                    r_ax_d[0][a][j] <= w_axis[a][j];
                    r_ax_d[1][a][j] <= r_ax_d[0][a][j];
                    r_ax_d[2][a][j] <= r_ax_d[1][a][j];
                end
                r_f_dot[a] <= DOT_W'(r_e_prod[a][0]) + DOT_W'(r_e_prod[a][1])
                            + DOT_W'(r_e_prod[a][2]);
                r_g_neg[a] <= r_f_dot[a][DOT_W-1];
                r_g_mag[a] <= (r_f_dot[a][DOT_W-1] ? DOT_W'(-r_f_dot[a]) : DOT_W'(r_f_dot[a]))
                            + DOT_W'(vmcb_pkg::ROUND_BIAS);
            end
            r_out.right_x    <= r_ax_d[2][0][0];
            r_out.right_y    <= r_ax_d[2][0][1];
            r_out.right_z    <= r_ax_d[2][0][2];
            r_out.up_out_x   <= r_ax_d[2][1][0];
            r_out.up_out_y   <= r_ax_d[2][1][1];
            r_out.up_out_z   <= r_ax_d[2][1][2];
            r_out.look_out_x <= r_ax_d[2][2][0];
            r_out.look_out_y <= r_ax_d[2][2][1];
            r_out.look_out_z <= r_ax_d[2][2][2];
            r_out.trans_x    <= n_t[0];
            r_out.trans_y    <= n_t[1];
            r_out.trans_z    <= n_t[2];
        end
    end

endmodule

`default_nettype wire
